[rtl/polyline_closest_point_core_macros.svh]
// ----------------------------------------------------------------------------
// Polyline closest point core assertion macros
// Concurrent property wrappers clocked on i_clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_CLOSEST_POINT_CORE_MACROS_SVH
`define POLYLINE_CLOSEST_POINT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pcp_pkg.sv]
// ----------------------------------------------------------------------------
// Polyline closest point package
// Controller states and the command / status bundles between control and datapath.
// ----------------------------------------------------------------------------
package pcp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DXX,
        ST_MUL_DYY,
        ST_MUL_WXD,
        ST_MUL_WYD,
        ST_SUM_NUM,
        ST_DECIDE,
        ST_DIVIDE,
        ST_MUL_TX,
        ST_MUL_TY,
        ST_SUM_CY,
        ST_MUL_EX,
        ST_MUL_EY,
        ST_SUM_DIST,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        MS_DX_DX,
        MS_DY_DY,
        MS_WX_DX,
        MS_WY_DY,
        MS_DX_T,
        MS_DY_T,
        MS_EX_EX,
        MS_EY_EY
    } t_mul_sel;

    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_DEN_LD,
        ACC_DEN_ADD,
        ACC_NUM_LD,
        ACC_NUM_ADD,
        ACC_CX,
        ACC_CY,
        ACC_DIST_LD,
        ACC_DIST_ADD
    } t_acc_op;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc;
        logic     cand_a;
        logic     cand_b;
        logic     div_init;
        logic     div_step;
        logic     update;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic den_zero;
        logic num_le0;
        logic num_ge_den;
    } t_dp_stat;

endpackage

[rtl/polyline_closest_point_core.sv]
// A first vertex goes straight to emit, a vertex whose projection clamps to an end
// skips the divider, and any other runs it; only a last vertex strobes a result.
// busy falls as the result is strobed; start is taken again in the strobe cycle.
// The radix-2 divider (one quotient bit a cycle) and the one shared multiplier set the pace.
// Synchronous active-low reset clears prev and query point to zero and sets the best
// distance to all ones; results are strobed for one cycle, the receiver cannot stall.
// ----------------------------------------------------------------------------
// Polyline closest point core
// Closest point on a streamed polyline to a query point, with squared distance.
// ----------------------------------------------------------------------------
`include "polyline_closest_point_core_macros.svh"

module polyline_closest_point_core
    import pcp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic signed [COORD_BITS-1:0] i_query_x,
    input  logic signed [COORD_BITS-1:0] i_query_y,
    input  logic                         i_first_vertex,
    input  logic                         i_last_vertex,
    output logic                         o_res_valid,
    output logic signed [COORD_BITS-1:0] o_near_x,
    output logic signed [COORD_BITS-1:0] o_near_y,
    output logic [2*COORD_BITS:0]        o_dist_sq,
    output logic                         o_valid_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     res_zero;

    pcp_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_first_vertex(i_first_vertex),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_busy        (busy)
    );

    pcp_dp #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_query_x     (i_query_x),
        .i_query_y     (i_query_y),
        .i_first_vertex(i_first_vertex),
        .i_last_vertex (i_last_vertex),
        .o_res_valid   (o_res_valid),
        .o_near_x      (o_near_x),
        .o_near_y      (o_near_y),
        .o_dist_sq     (o_dist_sq),
        .o_valid_res   (o_valid_res)
    );

    assign res_zero = (o_dist_sq == '0) && (o_near_x == '0) && (o_near_y == '0);

    `PCP_ASSERT_SAME(a_strobe_when_idle, o_res_valid, !busy, "result strobe while busy")
    `PCP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `PCP_ASSERT_NEXT(a_strobe_single, o_res_valid, !o_res_valid, "result strobe held")
    `PCP_ASSERT_SAME(a_invalid_zero, o_res_valid && !o_valid_res, res_zero, "invalid result not zero")

endmodule

[rtl/pcp_ctrl.sv]
// ----------------------------------------------------------------------------
// Polyline closest point controller
// Sequences the shared multiplier, the clamp decision and the radix-2 divider.
// ----------------------------------------------------------------------------
module pcp_ctrl
    import pcp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_first_vertex,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    localparam int CW = $clog2(FRAC_BITS);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    t_dp_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = i_first_vertex ? ST_EMIT : ST_MUL_DXX;
                end
            end
            ST_MUL_DXX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DX_DX;
                n_state     = ST_MUL_DYY;
            end
            ST_MUL_DYY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DY_DY;
                cmd.acc     = ACC_DEN_LD;
                n_state     = ST_MUL_WXD;
            end
            ST_MUL_WXD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_WX_DX;
                cmd.acc     = ACC_DEN_ADD;
                n_state     = ST_MUL_WYD;
            end
            ST_MUL_WYD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_WY_DY;
                cmd.acc     = ACC_NUM_LD;
                n_state     = ST_SUM_NUM;
            end
            ST_SUM_NUM: begin
                cmd.acc = ACC_NUM_ADD;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                priority if (i_stat.den_zero || i_stat.num_le0) begin
                    cmd.cand_a = 1'b1;
                    n_state    = ST_MUL_EX;
                end else if (i_stat.num_ge_den) begin
                    cmd.cand_b = 1'b1;
                    n_state    = ST_MUL_EX;
                end else begin
                    cmd.div_init = 1'b1;
                    n_cnt        = '0;
                    n_state      = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (r_cnt == CW'(FRAC_BITS - 1)) begin
                    n_state = ST_MUL_TX;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MUL_TX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DX_T;
                n_state     = ST_MUL_TY;
            end
            ST_MUL_TY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DY_T;
                cmd.acc     = ACC_CX;
                n_state     = ST_SUM_CY;
            end
            ST_SUM_CY: begin
                cmd.acc = ACC_CY;
                n_state = ST_MUL_EX;
            end
            ST_MUL_EX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_EX_EX;
                n_state     = ST_MUL_EY;
            end
            ST_MUL_EY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_EY_EY;
                cmd.acc     = ACC_DIST_LD;
                n_state     = ST_SUM_DIST;
            end
            ST_SUM_DIST: begin
                cmd.acc = ACC_DIST_ADD;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                n_state  = ST_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != ST_IDLE);

endmodule

[rtl/pcp_dp.sv]
// ----------------------------------------------------------------------------
// Polyline closest point datapath
// Segment deltas, shared multiplier, dot-product accumulators, restoring
// divider for the projection fraction, and the running best candidate.
// ----------------------------------------------------------------------------
module pcp_dp
    import pcp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_stat                     o_stat,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic signed [COORD_BITS-1:0] i_query_x,
    input  logic signed [COORD_BITS-1:0] i_query_y,
    input  logic                         i_first_vertex,
    input  logic                         i_last_vertex,
    output logic                         o_res_valid,
    output logic signed [COORD_BITS-1:0] o_near_x,
    output logic signed [COORD_BITS-1:0] o_near_y,
    output logic [2*COORD_BITS:0]        o_dist_sq,
    output logic                         o_valid_res
);

    localparam int CB   = COORD_BITS;
    localparam int XW   = CB + 1;
    localparam int MW   = ((CB > FRAC_BITS) ? CB : FRAC_BITS) + 1;
    localparam int PW   = 2 * MW;
    localparam int DENW = 2 * CB + 2;
    localparam int NUMW = 2 * CB + 3;
    localparam int DW   = 2 * CB + 1;
    localparam int HALF = 1 << (FRAC_BITS - 1);

    // path state
    logic signed [CB-1:0]   r_prev_x, r_prev_y;
    logic signed [CB-1:0]   r_qx, r_qy;
    logic [DW-1:0]          r_best_dist;
    logic                   r_have_seg;
    logic                   r_out_valid;

    // per-item working registers
    logic                   r_last;
    logic signed [CB-1:0]   r_ax, r_ay;
    logic signed [XW-1:0]   r_dx, r_dy, r_wx, r_wy;
    logic signed [PW-1:0]   r_prod;
    logic [DENW-1:0]        r_den;
    logic signed [NUMW-1:0] r_num;
    logic [DENW-1:0]        r_rem;
    logic [FRAC_BITS-1:0]   r_quo;
    logic signed [CB-1:0]   r_cx, r_cy;
    logic [DW-1:0]          r_dist;
    logic signed [CB-1:0]   r_best_x, r_best_y;
    logic signed [CB-1:0]   r_out_x, r_out_y;
    logic [DW-1:0]          r_out_dist;
    logic                   r_out_vres;

    logic signed [XW-1:0]   ex, ey;
    logic signed [MW-1:0]   op_a, op_b;
    logic signed [MW-1:0]   t_ext;
    logic signed [PW-1:0]   rnd;
    logic signed [NUMW-1:0] den_s;
    logic [DENW:0]          rem2, den_w;
    logic                   rem_ge;
    logic                   take;

    assign ex    = XW'(r_qx) - XW'(r_cx);
    assign ey    = XW'(r_qy) - XW'(r_cy);
    assign t_ext = $signed(MW'(r_quo));

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_DX_DX: begin op_a = MW'(r_dx); op_b = MW'(r_dx); end
            MS_DY_DY: begin op_a = MW'(r_dy); op_b = MW'(r_dy); end
            MS_WX_DX: begin op_a = MW'(r_wx); op_b = MW'(r_dx); end
            MS_WY_DY: begin op_a = MW'(r_wy); op_b = MW'(r_dy); end
            MS_DX_T:  begin op_a = MW'(r_dx); op_b = t_ext;     end
            MS_DY_T:  begin op_a = MW'(r_dy); op_b = t_ext;     end
            MS_EX_EX: begin op_a = MW'(ex);   op_b = MW'(ex);   end
            MS_EY_EY: begin op_a = MW'(ey);   op_b = MW'(ey);   end
        endcase
    end

    // round half up, then floor back to coordinate scale
    assign rnd = (r_prod + PW'(HALF)) >>> FRAC_BITS;

    assign den_s  = {1'b0, r_den};
    assign rem2   = {r_rem, 1'b0};
    assign den_w  = {1'b0, r_den};
    assign rem_ge = (rem2 >= den_w);
    assign take   = (r_dist <= r_best_dist);

    assign o_stat.den_zero   = (r_den == '0);
    assign o_stat.num_le0    = r_num[NUMW-1] || (r_num == '0);
    assign o_stat.num_ge_den = (r_num >= den_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_qx        <= '0;
            r_qy        <= '0;
            r_best_dist <= '1;
            r_have_seg  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit && r_last;
            if (i_cmd.load) begin
                r_prev_x <= i_vertex_x;
                r_prev_y <= i_vertex_y;
                if (i_first_vertex) begin
                    r_qx        <= i_query_x;
                    r_qy        <= i_query_y;
                    r_best_dist <= '1;
                    r_have_seg  <= 1'b0;
                end
            end
            if (i_cmd.update) begin
                if (take) begin
                    r_best_dist <= r_dist;
                end
                r_have_seg <= 1'b1;
            end
            if (i_cmd.emit && r_last) begin
                r_best_dist <= '1;
                r_have_seg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_last_vertex;
            r_ax   <= r_prev_x;
            r_ay   <= r_prev_y;
            r_dx   <= XW'(i_vertex_x) - XW'(r_prev_x);
            r_dy   <= XW'(i_vertex_y) - XW'(r_prev_y);
            r_wx   <= XW'(r_qx) - XW'(r_prev_x);
            r_wy   <= XW'(r_qy) - XW'(r_prev_y);
        end

        if (i_cmd.mul_en) begin
            r_prod <= op_a * op_b;
        end

        unique case (i_cmd.acc)
            ACC_DEN_LD:   r_den  <= DENW'(r_prod);
            ACC_DEN_ADD:  r_den  <= r_den + DENW'(r_prod);
            ACC_NUM_LD:   r_num  <= NUMW'(r_prod);
            ACC_NUM_ADD:  r_num  <= r_num + NUMW'(r_prod);
            ACC_CX:       r_cx   <= CB'(XW'(r_ax) + XW'(rnd));
            ACC_CY:       r_cy   <= CB'(XW'(r_ay) + XW'(rnd));
            ACC_DIST_LD:  r_dist <= DW'(r_prod);
            ACC_DIST_ADD: r_dist <= r_dist + DW'(r_prod);
            default: ;
        endcase

        // clamped ends: start vertex, or end vertex now held as prev
        if (i_cmd.cand_a) begin
            r_cx <= r_ax;
            r_cy <= r_ay;
        end
        if (i_cmd.cand_b) begin
            r_cx <= r_prev_x;
            r_cy <= r_prev_y;
        end

        if (i_cmd.div_init) begin
            r_rem <= DENW'(r_num);
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? DENW'(rem2 - den_w) : DENW'(rem2);
            r_quo <= {r_quo[FRAC_BITS-2:0], rem_ge};
        end

        if (i_cmd.update && take) begin
            r_best_x <= r_cx;
            r_best_y <= r_cy;
        end

        if (i_cmd.emit && r_last) begin
            r_out_x    <= r_have_seg ? r_best_x : '0;
            r_out_y    <= r_have_seg ? r_best_y : '0;
            r_out_dist <= r_have_seg ? r_best_dist : '0;
            r_out_vres <= r_have_seg;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_near_x    = r_out_x;
    assign o_near_y    = r_out_y;
    assign o_dist_sq   = r_out_dist;
    assign o_valid_res = r_out_vres;

endmodule
